>>> sv/acpf_pkg.sv
// package for the autocorrelation loop point finder
// word types, sizes, codes and divider handshake structs; no dependencies
`default_nettype none
package acpf_pkg;

  localparam int MAX_SAMPLES = 16384;
  localparam int ADDR_W      = 14;
  localparam int CNT_W       = 15;
  localparam int LAG_W       = 14;
  localparam int ACC_W       = 48;
  localparam int PROD_W      = 62;
  localparam int RATE_W      = 18;
  localparam int DVS_W       = 9;

  localparam logic [CNT_W-1:0]  MIN_LENGTH = 15'd1024;
  localparam logic [DVS_W-1:0]  HIGH_FREQ  = 9'd500;
  localparam logic [DVS_W-1:0]  LOW_FREQ   = 9'd80;
  localparam logic [DVS_W-1:0]  THIRD_DIV  = 9'd3;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

  // reciprocals: ceil(2^16/3), ceil(2^23/125) after a shift by 2, ceil(2^16/5) after a shift by 4
  localparam logic [15:0] RECIP_THIRD = 16'd21846;
  localparam logic [16:0] RECIP_HIGH  = 17'd67109;
  localparam logic [13:0] RECIP_LOW   = 14'd13108;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_OVF   = 2'd2;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] start_pt;
    logic [13:0] end_pt;
    logic [13:0] period;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> sv/acpf_smem.sv
// sample memory: one write port, two registered read ports
// uses acpf_pkg
`default_nettype none
module acpf_smem (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [acpf_pkg::ADDR_W-1:0] waddr,
  input  wire logic signed [15:0]        wdata,
  input  wire logic [acpf_pkg::ADDR_W-1:0] raddr_a,
  input  wire logic [acpf_pkg::ADDR_W-1:0] raddr_b,
  output logic signed [15:0]             rdata_a,
  output logic signed [15:0]             rdata_b
);

  logic signed [15:0] mem [acpf_pkg::MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

>>> sv/acpf_div.sv
// divider for the three fixed divisors by reciprocal multiplication
// quotient and done are registered, valid in the cycle after start; uses acpf_pkg
`default_nettype none
module acpf_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire acpf_pkg::div_req_t req,
  output acpf_pkg::div_rsp_t      rsp
);

  logic                          done_r;
  logic [acpf_pkg::RATE_W-1:0]   quo_r;
  logic [acpf_pkg::RATE_W-1:0]   quo_nxt;
  logic [30:0]                   prod_third;
  logic [32:0]                   prod_high;
  logic [27:0]                   prod_low;

  // exact for a length below 2^15 and any 18-bit rate
  assign prod_third = 31'(req.dividend[14:0]) * 31'(acpf_pkg::RECIP_THIRD);
  assign prod_high  = 33'(req.dividend[17:2]) * 33'(acpf_pkg::RECIP_HIGH);
  assign prod_low   = 28'(req.dividend[17:4]) * 28'(acpf_pkg::RECIP_LOW);

  always_comb begin
    unique case (req.divisor)
      acpf_pkg::HIGH_FREQ: begin
        quo_nxt = acpf_pkg::RATE_W'(prod_high[32:23]);
      end
      acpf_pkg::LOW_FREQ: begin
        quo_nxt = acpf_pkg::RATE_W'(prod_low[27:16]);
      end
      default: begin
        quo_nxt = acpf_pkg::RATE_W'(prod_third[30:16]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= req.start;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

>>> sv/autocorrelation_loop_point_finder_core.sv
// autocorrelation loop point finder, top level
// uses acpf_pkg, acpf_smem, acpf_div
// Samples are taken one per cycle while loading into a 16384-entry sample
// memory; excess samples are dropped and flagged. After the word marked last,
// three constant divisions (length/3, rate/500, rate/80) run in turn. Each lag
// of the search then has a range check, an accumulate phase while the
// span-lag sample pairs stream through the memory's two read ports, a pipeline
// drain and a compare, plus two more compare steps when the lag is weighed
// against an earlier best. A last range check ends the search and the result
// word is loaded into the output register once that register is free. A
// block shorter than 1024 samples skips the divisions and the search and goes
// straight to the result word. Input is held off from the last word until the
// result word is loaded into the output register.
`default_nettype none
module autocorrelation_loop_point_finder_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire acpf_pkg::in_word_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output acpf_pkg::out_word_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [acpf_pkg::RATE_W-1:0]   cfg_wdata
);

  typedef enum logic [10:0] {
    S_LOAD    = 11'b00000000001,
    S_DIV_LEN = 11'b00000000010,
    S_DIV_MIN = 11'b00000000100,
    S_DIV_MAX = 11'b00000001000,
    S_LAG     = 11'b00000010000,
    S_ACC     = 11'b00000100000,
    S_DRAIN   = 11'b00001000000,
    S_CMP1    = 11'b00010000000,
    S_CMP2    = 11'b00100000000,
    S_CMP3    = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_t;

  localparam int AW = acpf_pkg::ADDR_W;
  localparam int CW = acpf_pkg::CNT_W;
  localparam int LW = acpf_pkg::LAG_W;

  state_t                         state_r;
  logic [acpf_pkg::RATE_W-1:0]    rate_r;
  logic [CW-1:0]                  count_r;
  logic                           ovf_r;
  logic [CW-1:0]                  len_r;
  logic                           blk_ovf_r;
  logic                           short_r;
  logic [LW-1:0]                  span_r;
  logic [LW-1:0]                  maxp_r;
  logic [LW-1:0]                  lag_r;
  logic [LW-1:0]                  terms_r;
  logic [LW-1:0]                  k_r;
  logic                           started_r;
  logic                           rd_v_r;
  logic                           prod_v_r;
  logic signed [31:0]             prod_r;
  logic signed [acpf_pkg::ACC_W-1:0] acc_r;
  logic [acpf_pkg::ACC_W-1:0]     best_sum_r;
  logic [LW-1:0]                  best_terms_r;
  logic [LW-1:0]                  best_lag_r;
  logic [acpf_pkg::PROD_W-1:0]    p1_r;
  logic [acpf_pkg::PROD_W-1:0]    p2_r;
  logic                           out_valid_r;
  acpf_pkg::out_word_t            out_r;

  logic                           in_fire;
  logic                           room;
  logic [CW-1:0]                  len_nxt;
  logic                           mem_we;
  logic [AW-1:0]                  raddr_a;
  logic [AW-1:0]                  raddr_b;
  logic signed [15:0]             rdata_a;
  logic signed [15:0]             rdata_b;
  acpf_pkg::div_req_t             dreq;
  acpf_pkg::div_rsp_t             drsp;
  logic [CW:0]                    base;
  logic [CW-1:0]                  mid;
  logic [CW:0]                    le_full;
  acpf_pkg::out_word_t            res;

  assign in_ready  = (state_r == S_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign room      = count_r < CW'(acpf_pkg::MAX_SAMPLES);
  assign len_nxt   = count_r + CW'(room);
  assign mem_we    = in_fire && room;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign base    = {1'b0, span_r} + (CW+1)'(k_r) + 16'd0;
  assign raddr_a = base[AW-1:0];
  assign raddr_b = AW'(base + (CW+1)'(lag_r));

  acpf_smem u_smem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (count_r[AW-1:0]),
    .wdata   (in_data.sample),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = acpf_pkg::RATE_W'(len_r);
    dreq.divisor  = acpf_pkg::THIRD_DIV;
    unique case (state_r)
      S_DIV_LEN: begin
        dreq.start = !started_r;
      end
      S_DIV_MIN: begin
        dreq.start    = !started_r;
        dreq.dividend = rate_r;
        dreq.divisor  = acpf_pkg::HIGH_FREQ;
      end
      S_DIV_MAX: begin
        dreq.start    = !started_r;
        dreq.dividend = rate_r;
        dreq.divisor  = acpf_pkg::LOW_FREQ;
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  acpf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // loop points around the midpoint
  always_comb begin
    mid     = len_r >> 1;
    le_full = {1'b0, mid} + (CW+1)'(best_lag_r);
    if (le_full >= {1'b0, len_r}) begin
      le_full = {1'b0, len_r} - 16'd1;
    end
    res.status   = blk_ovf_r ? acpf_pkg::STATUS_OVF : acpf_pkg::STATUS_OK;
    res.start_pt = ({1'b0, best_lag_r} > mid) ? 14'd0 : 14'(mid - CW'(best_lag_r));
    res.end_pt   = le_full[13:0];
    res.period   = best_lag_r;
    if (short_r) begin
      res.status   = acpf_pkg::STATUS_SHORT;
      res.start_pt = '0;
      res.end_pt   = '0;
      res.period   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      rate_r      <= acpf_pkg::RATE_RESET;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      started_r   <= 1'b0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      rd_v_r   <= (state_r == S_ACC);
      prod_v_r <= rd_v_r;
      unique case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (in_data.last) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= (len_nxt < acpf_pkg::MIN_LENGTH) ? S_DONE : S_DIV_LEN;
            end else begin
              count_r <= len_nxt;
              ovf_r   <= ovf_r || !room;
            end
          end
        end
        S_DIV_LEN: begin
          if (dreq.start) begin
            started_r <= 1'b1;
          end
          if (drsp.done) begin
            started_r <= 1'b0;
            state_r   <= S_DIV_MIN;
          end
        end
        S_DIV_MIN: begin
          if (dreq.start) begin
            started_r <= 1'b1;
          end
          if (drsp.done) begin
            started_r <= 1'b0;
            state_r   <= S_DIV_MAX;
          end
        end
        S_DIV_MAX: begin
          if (dreq.start) begin
            started_r <= 1'b1;
          end
          if (drsp.done) begin
            started_r <= 1'b0;
            state_r   <= S_LAG;
          end
        end
        S_LAG: begin
          state_r <= (lag_r < maxp_r && lag_r < (span_r >> 1)) ? S_ACC : S_DONE;
        end
        S_ACC: begin
          if (k_r == terms_r - 14'd1) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v_r && !prod_v_r) begin
            state_r <= S_CMP1;
          end
        end
        S_CMP1: begin
          if (acc_r > 0 && best_terms_r != '0) begin
            state_r <= S_CMP2;
          end else begin
            state_r <= S_LAG;
          end
        end
        S_CMP2: begin
          state_r <= S_CMP3;
        end
        S_CMP3: begin
          state_r <= S_LAG;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= 32'(rdata_a) * 32'(rdata_b);
    if (prod_v_r) begin
      acc_r <= acc_r + acpf_pkg::ACC_W'(prod_r);
    end
    unique case (state_r)
      S_LOAD: begin
        if (in_fire && in_data.last) begin
          len_r     <= len_nxt;
          blk_ovf_r <= ovf_r || !room;
          short_r   <= len_nxt < acpf_pkg::MIN_LENGTH;
        end
      end
      S_DIV_LEN: begin
        if (drsp.done) begin
          span_r <= drsp.quotient[LW-1:0];
        end
      end
      S_DIV_MIN: begin
        if (drsp.done) begin
          lag_r        <= drsp.quotient[LW-1:0];
          best_lag_r   <= drsp.quotient[LW-1:0];
          best_sum_r   <= '0;
          best_terms_r <= '0;
        end
      end
      S_DIV_MAX: begin
        if (drsp.done) begin
          maxp_r <= drsp.quotient[LW-1:0];
        end
      end
      S_LAG: begin
        terms_r <= span_r - lag_r;
        k_r     <= '0;
        acc_r   <= '0;
      end
      S_ACC: begin
        k_r <= k_r + 14'd1;
      end
      S_CMP1: begin
        p1_r <= acpf_pkg::PROD_W'(acc_r) * acpf_pkg::PROD_W'(best_terms_r);
        if (acc_r > 0 && best_terms_r == '0) begin
          best_sum_r   <= acc_r;
          best_terms_r <= terms_r;
          best_lag_r   <= lag_r;
        end
        if (!(acc_r > 0 && best_terms_r != '0)) begin
          lag_r <= lag_r + 14'd1;
        end
      end
      S_CMP2: begin
        p2_r <= acpf_pkg::PROD_W'(best_sum_r) * acpf_pkg::PROD_W'(terms_r);
      end
      S_CMP3: begin
        if (p1_r > p2_r) begin
          best_sum_r   <= acc_r;
          best_terms_r <= terms_r;
          best_lag_r   <= lag_r;
        end
        lag_r <= lag_r + 14'd1;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_r <= res;
        end
      end
      default: begin
        k_r <= k_r;
      end
    endcase
  end

`ifndef SYNTH
  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> !mem_we)
    else $error("sample write outside load");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (k_r < terms_r))
    else $error("read issue past term count");

  a_drain_before_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP1) |-> (!rd_v_r && !prod_v_r))
    else $error("compare with products in flight");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> ($past(state_r) == S_DONE))
    else $error("result word without finish");
`endif

endmodule
`default_nettype wire

>>> tb/acpf_checker.sv
// result checker for the autocorrelation loop point finder
// predicts each result word from accepted sample words and rate writes; uses acpf_pkg
`timescale 1ns / 1ps
module acpf_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire acpf_pkg::in_word_t          in_data,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire acpf_pkg::out_word_t         out_data,
  input  wire logic                        cfg_we,
  input  wire logic [acpf_pkg::RATE_W-1:0] cfg_wdata,
  output int                               pending,
  output int                               errors,
  output int                               results_seen
);

  shortint                     samples [acpf_pkg::MAX_SAMPLES];
  int                          stored;
  bit                          dropped;
  logic [acpf_pkg::RATE_W-1:0] rate;
  acpf_pkg::out_word_t         loop_points_q[$];

  // lag with the largest positive mean product over the middle third
  function automatic int find_period(int len, int unsigned fs);
    int        start, span, minp, maxp, best;
    longint    acc, best_acc;
    longint    best_n, n;
    start = len / 3;
    span = len / 3;
    minp = fs / 500;
    maxp = fs / 80;
    best = minp;
    best_acc = 0;
    best_n = 0;
    for (int lag = minp; lag < maxp && lag < span / 2; lag++) begin
      n = span - lag;
      acc = 0;
      for (int i = start; i < start + n; i++)
        acc += longint'(samples[i]) * longint'(samples[i + lag]);
      if (acc > 0 && (best_n == 0 || acc * best_n > best_acc * n)) begin
        best_acc = acc;
        best_n = n;
        best = lag;
      end
    end
    return best;
  endfunction

  function automatic acpf_pkg::out_word_t predict_loop(int len, bit ovf, int unsigned fs);
    acpf_pkg::out_word_t r;
    int        per, mid, ls, le;
    r = '0;
    if (len < int'(acpf_pkg::MIN_LENGTH)) begin
      r.status = acpf_pkg::STATUS_SHORT;
    end else begin
      per = find_period(len, fs);
      mid = len / 2;
      ls = (per > mid) ? 0 : mid - per;
      le = mid + per;
      if (le >= len) le = len - 1;
      r.status = ovf ? acpf_pkg::STATUS_OVF : acpf_pkg::STATUS_OK;
      r.start_pt = ls[13:0];
      r.end_pt = le[13:0];
      r.period = per[13:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    acpf_pkg::out_word_t want;
    if (!rst_n) begin
      stored = 0;
      dropped = 0;
      rate <= acpf_pkg::RATE_RESET;
      loop_points_q.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) rate <= cfg_wdata;
      if (in_valid && in_ready) begin
        if (stored < acpf_pkg::MAX_SAMPLES) begin
          samples[stored] = in_data.sample;
          stored = stored + 1;
        end else begin
          dropped = 1;
        end
        if (in_data.last) begin
          loop_points_q.push_back(predict_loop(stored, dropped, rate));
          stored = 0;
          dropped = 0;
        end
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (loop_points_q.size() == 0) begin
          if (errors < 10) $display("unexpected result word %p", out_data);
          errors <= errors + 1;
        end else begin
          want = loop_points_q.pop_front();
          if (want.status !== out_data.status || want.start_pt !== out_data.start_pt ||
              want.end_pt !== out_data.end_pt || want.period !== out_data.period) begin
            if (errors < 10)
              $display("result mismatch: expected %p actual %p", want, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= loop_points_q.size();
  end

endmodule

>>> tb/tb_autocorrelation_loop_point_finder_core.sv
// testbench top for autocorrelation_loop_point_finder_core
// drives sample blocks, rate writes and idle/stall phases; uses acpf_pkg and acpf_checker
`timescale 1ns / 1ps
module tb_autocorrelation_loop_point_finder_core;

  logic                        clk = 0;
  logic                        rst_n = 0;
  logic                        in_valid = 0;
  logic                        in_ready;
  acpf_pkg::in_word_t          in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 0;
  acpf_pkg::out_word_t         out_data;
  logic                        cfg_we = 0;
  logic [acpf_pkg::RATE_W-1:0] cfg_wdata = '0;
  int                          pending, errors, results_seen;
  int                          idle_pct = 0, stall_pct = 0;
  int                          n_blocks = 0, n_long = 0;

  always #1 clk = ~clk;

  autocorrelation_loop_point_finder_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  acpf_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pending(pending), .errors(errors), .results_seen(results_seen)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_word(input logic signed [15:0] s, input logic lst);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{sample: s, last: lst};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rate(input logic [acpf_pkg::RATE_W-1:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // modes: 0 random, 1 silence, 2 noisy sawtooth, 3 full-scale random sign, 4 square
  function automatic logic signed [15:0] gen_sample(int i, int mode, int per);
    int ph, v;
    ph = i % per;
    case (mode)
      0: v = $signed(16'($urandom));
      1: v = 0;
      2: v = (ph * 60000) / per - 30000 + $urandom_range(0, 255) - 128;
      3: v = $urandom_range(1) ? 32767 : -32768;
      default: v = (ph < per / 2) ? 20000 : -20000;
    endcase
    return 16'(v);
  endfunction

  task automatic send_block(int len, int mode, int per);
    for (int i = 0; i < len; i++) push_word(gen_sample(i, mode, per), i == len - 1);
    n_blocks++;
    if (len >= int'(acpf_pkg::MIN_LENGTH)) n_long++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, tiny blocks, one block long enough for a search
    push_word(16'sh7fff, 1);
    n_blocks++;
    push_word(-16'sd32768, 0);
    push_word(-16'sd1, 0);
    push_word(16'sd0, 1);
    n_blocks++;
    write_rate(18'd8000);
    send_block(1024, 2, 40);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; write_rate(18'd0); end
        1: begin idle_pct = 48; stall_pct = 0; write_rate(18'd192000); end
        2: begin idle_pct = 0; stall_pct = 48; write_rate(18'h3ffff); end
        default: begin
          idle_pct = 13; stall_pct = 13;
          write_rate(18'($urandom_range(8000, 16000)));
        end
      endcase
      for (int b = 0; b < 8; b++) begin
        send_block($urandom_range(1, 20), $urandom_range(0, 4), $urandom_range(2, 9));
        if (ph == 1 && b == 4) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("ran %0d sample blocks, %0d of them long enough for a period search",
             n_blocks, n_long);
    $display("%0d result words checked under several rates and idle/stall mixes",
             results_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/acpf_pkg.sv
sv/acpf_smem.sv
sv/acpf_div.sv
sv/autocorrelation_loop_point_finder_core.sv
tb/acpf_checker.sv
tb/tb_autocorrelation_loop_point_finder_core.sv
